/* hw/rtl/adsr_pkg.sv */
// Shared types and constants for the ADSR envelope modulator.
`timescale 1ns / 1ps

package adsr_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DUR_W = 16;
  localparam int unsigned LEVEL_W = 17;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PARAM_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd4;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;
  localparam logic [PARAM_W:0] PARAM_SPAN = 19'd262144;
  localparam logic [PARAM_W-1:0] PARAM_MAX = 18'd262143;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'h8000;

  // shared multiply/divide unit geometry
  localparam int unsigned MDU_A_W = 35;
  localparam int unsigned MDU_B_W = 17;
  localparam int unsigned MDU_P_W = MDU_A_W + MDU_B_W;
  localparam int unsigned MDU_STEPS = MDU_B_W;
  localparam int unsigned MDU_CNT_W = $clog2(MDU_STEPS);

  typedef enum logic [1:0] {
    STG_ATTACK = 2'd0,
    STG_DECAY = 2'd1,
    STG_SUSTAIN = 2'd2,
    STG_RELEASE = 2'd3
  } stage_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic start;
    mdu_op_t op;
    logic [MDU_A_W-1:0] a;
    logic [MDU_B_W-1:0] b;
  } mdu_req_t;

  typedef struct packed {
    logic done;
    logic [MDU_P_W-1:0] result;
  } mdu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAN,
    ST_STAGE,
    ST_CAP_MUL,
    ST_CAP_DIV,
    ST_LVL_MUL,
    ST_LVL_DIV,
    ST_MOD,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } fsm_state_t;

endpackage

/* hw/rtl/adsr_mdu.sv */
// Radix-2 shift-add multiplier and restoring divider sharing one adder.
`timescale 1ns / 1ps

module adsr_mdu
  import adsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mdu_req_t req,
  output mdu_rsp_t rsp
);

  logic                 busy;
  logic                 done_r;
  logic [MDU_CNT_W-1:0] cnt;
  mdu_op_t              op_r;
  logic [MDU_A_W:0]     hi;
  logic [MDU_B_W-1:0]   lo;
  logic [MDU_A_W-1:0]   mcand;

  logic                 is_div;
  logic [MDU_A_W:0]     add_x;
  logic [MDU_A_W:0]     add_y;
  logic [MDU_A_W+1:0]   sum;
  logic                 no_borrow;

  assign is_div = (op_r == MDU_DIV);

  always_comb begin
    if (is_div) begin
      add_x = {19'd0, hi[15:0], lo[MDU_B_W-1]};
      add_y = {20'd0, mcand[15:0]};
    end else begin
      add_x = hi;
      add_y = lo[0] ? {1'b0, mcand} : '0;
    end
    sum = {1'b0, add_x} + {1'b0, add_y ^ {(MDU_A_W+1){is_div}}} + (MDU_A_W+2)'(is_div);
  end

  assign no_borrow = sum[MDU_A_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_r <= 1'b0;
      cnt <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= MDU_CNT_W'(MDU_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      if (req.op == MDU_DIV) begin
        mcand <= MDU_A_W'(req.b);
        hi <= {20'd0, req.a[32:17]};
        lo <= req.a[16:0];
      end else begin
        mcand <= req.a;
        hi <= '0;
        lo <= req.b;
      end
    end else if (busy) begin
      if (is_div) begin
        hi <= no_borrow ? {19'd0, sum[16:0]} : {19'd0, hi[15:0], lo[MDU_B_W-1]};
        lo <= {lo[MDU_B_W-2:0], no_borrow};
      end else begin
        hi <= {1'b0, sum[MDU_A_W:1]};
        lo <= {sum[0], lo[MDU_B_W-1:1]};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.result = is_div ? {{MDU_A_W{1'b0}}, lo} : {hi[MDU_A_W-1:0], lo};

endmodule

/* hw/rtl/adsr_envelope_modulator_top.sv */
// Top level of the ADSR envelope modulator: registers, envelope sequencer, output stage.
// Usage:
//   Input channel (in_valid / in_stall) carries now_ms, param_in and note_on.
//   in_stall is low only while the sequencer is idle; a request is taken at an
//   edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) carries param_out, stage and active,
//   one result per request, held in an output register until taken. A new
//   request may be accepted while that result waits.
//   Configuration is written through cfg_write / cfg_index / cfg_data while no
//   request is in flight; unknown indexes are dropped.
// Sequencing:
//   Levels and modulation run on one shared multiply/divide unit. An idle
//   envelope goes from PLAN straight to DONE and a stage change through
//   STAGE to DONE; a sustain level takes 2 passes of the unit, an attack
//   level 3, and a decay or release level, or a release capture from decay, 4.
//   The next request is taken at the edge after the one that loads
//   out_valid at the earliest. The sequencer waits in its final state while
//   the output register is still full and out_stall is high.
// Reset:
//   rst clears the envelope to attack, not running, no capture, and sets the
//   registers to zero durations, zero sustain and depth -1.0.
`timescale 1ns / 1ps

module adsr_envelope_modulator_top
  import adsr_pkg::*;
#(
  parameter int unsigned MAX_TIME_MS = 65535
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [PARAM_W-1:0]    param_in,
  input  logic                  note_on,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PARAM_W-1:0]    param_out,
  output logic [1:0]            stage,
  output logic                  active
);

  logic [DUR_W-1:0]   attack_ms;
  logic [DUR_W-1:0]   decay_ms;
  logic [LEVEL_W-1:0] sustain_level;
  logic [DUR_W-1:0]   release_ms;
  logic [DEPTH_W-1:0] mod_depth;

  fsm_state_t         state, state_next;
  stage_t             stage_reg, stage_next;
  logic               running, running_next;
  logic               released, released_next;
  logic [TIME_W-1:0]  stage_start, start_next;
  logic [LEVEL_W-1:0] rel_level, rel_level_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic [DUR_W-1:0]   divisor, divisor_next;
  logic               decay_kind, decay_next;
  logic [PARAM_W-1:0] res, res_next;
  logic               load_out;
  logic               go_rel;

  logic [TIME_W-1:0]  item_now;
  logic [PARAM_W-1:0] item_param;
  logic               item_gate;

  logic [DUR_W-1:0]   a_dur, d_dur, r_dur;
  logic [LEVEL_W-1:0] sus;
  logic [TIME_W-1:0]  t;
  logic [TIME_W-1:0]  t_att;
  logic               depth_pos;
  logic [MDU_B_W-1:0] mag;
  logic [PARAM_W:0]   factor;
  logic [20:0]        offset;
  logic [PARAM_W+3:0] up_sum;
  logic [PARAM_W-1:0] mod_out;

  mdu_req_t           req;
  mdu_rsp_t           rsp;

  adsr_mdu u_mdu (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ms <= '0;
      decay_ms <= '0;
      sustain_level <= '0;
      release_ms <= '0;
      mod_depth <= DEPTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ATTACK: attack_ms <= cfg_data[DUR_W-1:0];
        CFG_DECAY: decay_ms <= cfg_data[DUR_W-1:0];
        CFG_SUSTAIN: sustain_level <= cfg_data[LEVEL_W-1:0];
        CFG_RELEASE: release_ms <= cfg_data[DUR_W-1:0];
        CFG_DEPTH: mod_depth <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    a_dur = ({16'd0, attack_ms} > TIME_W'(MAX_TIME_MS)) ? DUR_W'(MAX_TIME_MS) : attack_ms;
    d_dur = ({16'd0, decay_ms} > TIME_W'(MAX_TIME_MS)) ? DUR_W'(MAX_TIME_MS) : decay_ms;
    r_dur = ({16'd0, release_ms} > TIME_W'(MAX_TIME_MS)) ? DUR_W'(MAX_TIME_MS) : release_ms;
    sus = (sustain_level > LEVEL_ONE) ? LEVEL_ONE : sustain_level;
  end

  assign t = item_now - stage_start;
  assign t_att = running ? t : '0;

  assign depth_pos = !mod_depth[DEPTH_W-1] && (mod_depth != '0);
  assign mag = depth_pos ? {1'b0, mod_depth} : (17'd0 - {mod_depth[DEPTH_W-1], mod_depth});
  assign factor = depth_pos ? (PARAM_SPAN - {1'b0, item_param}) : {1'b0, item_param};
  assign offset = rsp.result[51:31];
  assign up_sum = {4'd0, item_param} + {1'b0, offset};

  always_comb begin
    if (depth_pos) begin
      mod_out = (up_sum > (PARAM_W+4)'(PARAM_MAX)) ? PARAM_MAX : up_sum[PARAM_W-1:0];
    end else if (offset > {3'd0, item_param}) begin
      mod_out = '0;
    end else begin
      mod_out = PARAM_W'({3'd0, item_param} - offset);
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    stage_next = stage_reg;
    running_next = running;
    released_next = released;
    start_next = stage_start;
    rel_level_next = rel_level;
    level_next = level;
    divisor_next = divisor;
    decay_next = decay_kind;
    res_next = res;
    load_out = 1'b0;
    go_rel = 1'b0;
    req = '0;
    req.op = MDU_MUL;

    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PLAN;
      end
      ST_PLAN: begin
        if (!item_gate && !running) begin
          res_next = item_param;
          state_next = ST_DONE;
        end else if (!item_gate && !released) begin
          state_next = ST_STAGE;
          case (stage_reg)
            STG_ATTACK: begin
              if (a_dur == '0 || t >= {16'd0, a_dur}) begin
                rel_level_next = LEVEL_ONE;
                go_rel = 1'b1;
              end else begin
                req.start = 1'b1;
                req.op = MDU_DIV;
                req.a = MDU_A_W'({t[15:0], 16'd0});
                req.b = {1'b0, a_dur};
                state_next = ST_CAP_DIV;
              end
            end
            STG_DECAY: begin
              if (d_dur == '0 || t >= {16'd0, d_dur}) begin
                rel_level_next = sus;
                go_rel = 1'b1;
              end else begin
                req.start = 1'b1;
                req.op = MDU_MUL;
                req.a = MDU_A_W'(LEVEL_ONE - sus);
                req.b = {1'b0, t[15:0]};
                divisor_next = d_dur;
                state_next = ST_CAP_MUL;
              end
            end
            STG_SUSTAIN: begin
              rel_level_next = sus;
              go_rel = 1'b1;
            end
            default: go_rel = 1'b1;
          endcase
        end else if (item_gate && released) begin
          start_next = item_now;
          stage_next = STG_ATTACK;
          released_next = 1'b0;
          state_next = ST_STAGE;
        end else begin
          state_next = ST_STAGE;
        end
      end
      ST_CAP_MUL: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op = MDU_DIV;
          req.a = MDU_A_W'(rsp.result[32:0]);
          req.b = {1'b0, divisor};
          state_next = ST_CAP_DIV;
        end
      end
      ST_CAP_DIV: begin
        if (rsp.done) begin
          if (stage_reg == STG_DECAY) begin
            rel_level_next = LEVEL_ONE - rsp.result[LEVEL_W-1:0];
          end else begin
            rel_level_next = rsp.result[LEVEL_W-1:0];
          end
          go_rel = 1'b1;
          state_next = ST_STAGE;
        end
      end
      ST_STAGE: begin
        case (stage_reg)
          STG_ATTACK: begin
            if (!running) begin
              running_next = 1'b1;
              start_next = item_now;
            end
            if (t_att < {16'd0, a_dur}) begin
              req.start = 1'b1;
              req.op = MDU_DIV;
              req.a = MDU_A_W'({t_att[15:0], 16'd0});
              req.b = {1'b0, a_dur};
              decay_next = 1'b0;
              state_next = ST_LVL_DIV;
            end else begin
              start_next = item_now;
              stage_next = STG_DECAY;
              res_next = item_param;
              state_next = ST_DONE;
            end
          end
          STG_DECAY: begin
            if (t < {16'd0, d_dur}) begin
              req.start = 1'b1;
              req.op = MDU_MUL;
              req.a = MDU_A_W'(LEVEL_ONE - sus);
              req.b = {1'b0, t[15:0]};
              divisor_next = d_dur;
              decay_next = 1'b1;
              state_next = ST_LVL_MUL;
            end else begin
              start_next = item_now;
              stage_next = STG_SUSTAIN;
              res_next = item_param;
              state_next = ST_DONE;
            end
          end
          STG_SUSTAIN: begin
            if (item_gate) begin
              level_next = sus;
              state_next = ST_MOD;
            end else begin
              start_next = item_now;
              stage_next = STG_RELEASE;
              res_next = item_param;
              state_next = ST_DONE;
            end
          end
          default: begin
            if (t < {16'd0, r_dur}) begin
              if (t == '0) begin
                level_next = rel_level;
                state_next = ST_MOD;
              end else begin
                req.start = 1'b1;
                req.op = MDU_MUL;
                req.a = MDU_A_W'(rel_level);
                req.b = {1'b0, r_dur - t[15:0]};
                divisor_next = r_dur;
                decay_next = 1'b0;
                state_next = ST_LVL_MUL;
              end
            end else begin
              start_next = item_now;
              stage_next = STG_ATTACK;
              running_next = 1'b0;
              res_next = item_param;
              state_next = ST_DONE;
            end
          end
        endcase
      end
      ST_LVL_MUL: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op = MDU_DIV;
          req.a = MDU_A_W'(rsp.result[32:0]);
          req.b = {1'b0, divisor};
          state_next = ST_LVL_DIV;
        end
      end
      ST_LVL_DIV: begin
        if (rsp.done) begin
          level_next = decay_kind ? (LEVEL_ONE - rsp.result[LEVEL_W-1:0])
                                  : rsp.result[LEVEL_W-1:0];
          req.start = 1'b1;
          req.op = MDU_MUL;
          req.a = MDU_A_W'(factor);
          req.b = mag;
          state_next = ST_MUL1;
        end
      end
      ST_MOD: begin
        req.start = 1'b1;
        req.op = MDU_MUL;
        req.a = MDU_A_W'(factor);
        req.b = mag;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op = MDU_MUL;
          req.a = rsp.result[MDU_A_W-1:0];
          req.b = level;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (rsp.done) begin
          res_next = mod_out;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (go_rel) begin
      start_next = item_now;
      stage_next = STG_RELEASE;
      released_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage_reg <= STG_ATTACK;
      running <= 1'b0;
      released <= 1'b0;
      stage_start <= '0;
      rel_level <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      stage_reg <= stage_next;
      running <= running_next;
      released <= released_next;
      stage_start <= start_next;
      rel_level <= rel_level_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    level <= level_next;
    divisor <= divisor_next;
    decay_kind <= decay_next;
    res <= res_next;
    if (state == ST_IDLE && in_valid) begin
      item_now <= now_ms;
      item_param <= param_in;
      item_gate <= note_on;
    end
    if (load_out) begin
      param_out <= res;
      stage <= stage_reg;
      active <= running;
    end
  end

endmodule

/* tb/adsr_envelope_modulator_top_tb.sv */
// Self-checking testbench for the ADSR envelope modulator: directed stage walks plus random notes.
`timescale 1ns / 1ps

module adsr_envelope_modulator_top_tb
  import adsr_pkg::*;
;

  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TAIL_CYCLES = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_C = 3'd7;

  typedef struct {
    logic [PARAM_W-1:0] param;
    stage_t stg;
    logic act;
  } envelope_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ATTACK;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TIME_W-1:0] now_ms = '0;
  logic [PARAM_W-1:0] param_in = '0;
  logic note_on = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PARAM_W-1:0] param_out;
  logic [1:0] stage;
  logic active;

  logic [DUR_W-1:0] attack_len = '0;
  logic [DUR_W-1:0] decay_len = '0;
  logic [DUR_W-1:0] release_len = '0;
  logic [LEVEL_W-1:0] sustain_set = '0;
  logic signed [DEPTH_W-1:0] depth_set = DEPTH_RESET;

  stage_t env_stage = STG_ATTACK;
  logic env_running = 1'b0;
  logic env_released = 1'b0;
  logic [TIME_W-1:0] env_start = '0;
  logic [LEVEL_W-1:0] env_release_level = '0;

  envelope_out_t predicted_outputs[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles = 0;
  bit calm = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;

  adsr_envelope_modulator_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_ms(now_ms),
    .param_in(param_in),
    .note_on(note_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .param_out(param_out),
    .stage(stage),
    .active(active)
  );

  always #6 clk = ~clk;

  function automatic logic [LEVEL_W-1:0] sustain_clamped();
    return (sustain_set > LEVEL_ONE) ? LEVEL_ONE : sustain_set;
  endfunction

  function automatic logic [LEVEL_W-1:0] attack_level(logic [TIME_W-1:0] t);
    longint unsigned q;
    if (attack_len == 0 || t >= attack_len) return LEVEL_ONE;
    q = (longint'(t) << 16) / attack_len;
    return q[LEVEL_W-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] decay_level(logic [TIME_W-1:0] t);
    logic [LEVEL_W-1:0] s;
    longint unsigned drop;
    s = sustain_clamped();
    if (decay_len == 0 || t >= decay_len) return s;
    drop = (longint'(LEVEL_ONE - s) * t) / decay_len;
    return LEVEL_ONE - drop[LEVEL_W-1:0];
  endfunction

  function automatic logic [PARAM_W-1:0] modulate(logic [PARAM_W-1:0] p,
                                                  logic [LEVEL_W-1:0] lvl);
    longint base;
    longint scale;
    longint shift;
    longint sum;
    base = longint'(p);
    scale = longint'(depth_set);
    if (scale > 0) begin
      shift = (scale * (longint'(PARAM_SPAN) - base) * longint'(lvl)) >>> 31;
      sum = base + shift;
    end else begin
      shift = (-scale * base * longint'(lvl)) >>> 31;
      sum = base - shift;
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(PARAM_MAX)) sum = longint'(PARAM_MAX);
    return sum[PARAM_W-1:0];
  endfunction

  function automatic envelope_out_t predict_envelope(logic [TIME_W-1:0] now,
                                                     logic [PARAM_W-1:0] p, logic held);
    envelope_out_t res;
    logic [TIME_W-1:0] t;
    longint unsigned fall;
    t = now - env_start;
    res.param = p;
    if (held || env_running) begin
      if (!held && !env_released) begin
        env_start = now;
        case (env_stage)
          STG_ATTACK: env_release_level = attack_level(t);
          STG_DECAY: env_release_level = decay_level(t);
          STG_SUSTAIN: env_release_level = sustain_clamped();
          default: ;
        endcase
        env_stage = STG_RELEASE;
        t = '0;
        env_released = 1'b1;
      end else if (held && env_released) begin
        env_start = now;
        env_stage = STG_ATTACK;
        t = '0;
        env_released = 1'b0;
      end
      case (env_stage)
        STG_ATTACK: begin
          if (!env_running) begin
            env_running = 1'b1;
            env_start = now;
            t = '0;
          end
          if (t < attack_len) begin
            res.param = modulate(p, attack_level(t));
          end else begin
            env_start = now;
            env_stage = STG_DECAY;
          end
        end
        STG_DECAY: begin
          if (t < decay_len) begin
            res.param = modulate(p, decay_level(t));
          end else begin
            env_start = now;
            env_stage = STG_SUSTAIN;
          end
        end
        STG_SUSTAIN: begin
          if (held) begin
            res.param = modulate(p, sustain_clamped());
          end else begin
            env_start = now;
            env_stage = STG_RELEASE;
          end
        end
        default: begin
          if (t < release_len) begin
            fall = (longint'(env_release_level) * (release_len - t)) / release_len;
            res.param = modulate(p, fall[LEVEL_W-1:0]);
          end else begin
            env_start = now;
            env_stage = STG_ATTACK;
            env_running = 1'b0;
          end
        end
      endcase
    end
    res.stg = env_stage;
    res.act = env_running;
    return res;
  endfunction

  function automatic logic [PARAM_W-1:0] next_param();
    case ($urandom_range(15, 0))
      0: return '0;
      1: return PARAM_MAX;
      default: return PARAM_W'($urandom());
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] next_step();
    case ($urandom_range(19, 0))
      0: return $urandom();
      1, 2: return $urandom_range(70000, 0);
      default: return $urandom_range(12, 0);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_duration();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(7, 0))
      0: v = '0;
      1: v = 17'h0FFFF;
      default: v = CFG_DATA_W'($urandom_range(60, 1));
    endcase
    v[CFG_DATA_W-1] = 1'($urandom_range(1, 0));
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_sustain();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return LEVEL_ONE;
      2: return CFG_DATA_W'($urandom_range(131071, 65537));
      default: return CFG_DATA_W'($urandom_range(65536, 0));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_depth();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(7, 0))
      0: v = 17'h07FFF;
      1: v = 17'h08000;
      2: v = '0;
      default: v = CFG_DATA_W'($urandom());
    endcase
    v[CFG_DATA_W-1] = 1'($urandom_range(1, 0));
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_ATTACK: attack_len = data[DUR_W-1:0];
      CFG_DECAY: decay_len = data[DUR_W-1:0];
      CFG_SUSTAIN: sustain_set = data[LEVEL_W-1:0];
      CFG_RELEASE: release_len = data[DUR_W-1:0];
      CFG_DEPTH: depth_set = data[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] atk, logic [CFG_DATA_W-1:0] dec,
                           logic [CFG_DATA_W-1:0] sus, logic [CFG_DATA_W-1:0] rel,
                           logic [CFG_DATA_W-1:0] dep);
    drain_and_settle();
    write_reg(CFG_ATTACK, atk);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_SUSTAIN, sus);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_DEPTH, dep);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(logic [TIME_W-1:0] delta, logic [PARAM_W-1:0] p, logic held);
    int unsigned gap;
    gap = (!calm && $urandom_range(99, 0) < IDLE_PCT) ? $urandom_range(5, 1) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    clock_ms = clock_ms + delta;
    in_valid <= 1'b1;
    now_ms <= clock_ms;
    param_in <= p;
    note_on <= held;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted_outputs.push_back(predict_envelope(clock_ms, p, held));
    requests_sent++;
  endtask

  task automatic test_idle_passthrough();
    send_request(0, '0, 1'b0);
    send_request(5, PARAM_MAX, 1'b0);
    send_request(5, PARAM_MAX, 1'b1);
    send_request(1, 18'h2AAAA, 1'b1);
    send_request(1, 18'h15555, 1'b1);
    send_request(1, PARAM_MAX, 1'b0);
  endtask

  task automatic test_register_decode();
    configure(17'h10008, 17'h1000C, 17'h1FFFF, 17'h10006, 17'h17FFF);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '0);
    write_reg(CFG_SPARE_C, 17'h0AAAA);
    cfg_write <= 1'b0;
    @(posedge clk);
    send_request(3, 18'h10000, 1'b1);
    send_request(4, 18'h10000, 1'b1);
    send_request(4, 18'h10000, 1'b1);
    send_request(6, next_param(), 1'b1);
    send_request(6, PARAM_MAX, 1'b1);
    send_request(1, '0, 1'b0);
  endtask

  task automatic test_stage_walk();
    configure(17'd20, 17'd30, 17'd40000, 17'd25, 17'h08000);
    clock_ms = 32'hFFFF_FFF0;
    send_request(0, next_param(), 1'b1);
    send_request(10, next_param(), 1'b1);
    send_request(10, next_param(), 1'b1);
    send_request(15, next_param(), 1'b1);
    send_request(15, next_param(), 1'b1);
    send_request(10, PARAM_MAX, 1'b1);
    send_request(10, next_param(), 1'b0);
    send_request(12, next_param(), 1'b0);
    send_request(13, next_param(), 1'b0);
  endtask

  task automatic test_release_capture();
    configure(17'h0FFFF, 17'h0FFFF, 17'd0, 17'h0FFFF, 17'h04000);
    send_request(100, next_param(), 1'b1);
    send_request(40000, next_param(), 1'b1);
    send_request(1, next_param(), 1'b0);
    send_request(30000, next_param(), 1'b1);
    send_request(65535, next_param(), 1'b1);
    send_request(20000, next_param(), 1'b1);
    send_request(1, next_param(), 1'b0);
    send_request(70000, next_param(), 1'b0);
  endtask

  task automatic test_random_envelopes();
    int unsigned phase;
    int unsigned budget;
    int unsigned hold;
    int unsigned rel;
    phase = 0;
    clock_ms = $urandom();
    while (requests_sent < ITEM_TARGET) begin
      configure(pick_duration(), pick_duration(), pick_sustain(), pick_duration(),
                pick_depth());
      calm = (phase == 4 || phase == 5);
      budget = requests_sent + 60;
      while (requests_sent < budget) begin
        hold = $urandom_range(16, 1);
        repeat (hold) send_request(next_step(), next_param(), $urandom_range(9, 0) != 0);
        rel = $urandom_range(8, 1);
        repeat (rel) send_request(next_step(), next_param(), $urandom_range(9, 0) == 0);
      end
      calm = 1'b0;
      phase++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
  end

  always @(posedge clk) begin
    envelope_out_t want;
    if (!rst) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch($sformatf("result with none pending, param_out %0d", param_out));
        end else begin
          want = predicted_outputs.pop_front();
          if (param_out !== want.param || stage !== want.stg || active !== want.act) begin
            report_mismatch($sformatf("expected param %0d stage %0d active %0d, got %0d %0d %0d",
                                      want.param, want.stg, want.act,
                                      param_out, stage, active));
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_passthrough();
    test_register_decode();
    test_stage_walk();
    test_release_capture();
    test_random_envelopes();
    drain_and_settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
